FILE: src/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the page table walker
// Request and result payloads, controller command and status bundles,
// entry bit positions and the level index selector.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // Memory and address geometry
  localparam int MEM_WORDS_DEF    = 4096;
  localparam int LEVEL_INDEX_BITS = 9;
  localparam int VA_W             = 48;
  localparam int PA_W             = 52;
  localparam int PAGE_OFS_W       = 12;
  localparam int FRAME_W          = PA_W - PAGE_OFS_W;
  localparam int WORD_IDX_W       = FRAME_W + LEVEL_INDEX_BITS;
  localparam int ENTRY_W          = 64;
  localparam int WRITE_IDX_W      = 12;
  localparam int LEVELS           = 4;
  localparam int LEVEL_W          = $clog2(LEVELS);

  // Entry bit positions
  localparam int PTE_PRESENT = 0;
  localparam int PTE_USER    = 2;
  localparam int PTE_LARGE   = 7;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_LARGE       = 2'd2,
    ST_OUTSIDE     = 2'd3
  } walk_status_t;

  // Source of a finished result
  typedef enum logic [1:0] {
    FIN_ZERO = 2'd0,
    FIN_ROOT = 2'd1,
    FIN_STEP = 2'd2
  } fin_src_t;

  typedef struct packed {
    op_t                    operation;
    logic [WRITE_IDX_W-1:0] word_index;
    logic [ENTRY_W-1:0]     word_data;
    logic [VA_W-1:0]        virt_addr;
  } ptw_in_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    walk_status_t    walk_status;
    logic            user_ok;
  } ptw_out_t;

  // Controller to datapath
  typedef struct packed {
    logic     clr_write;
    logic     start_write;
    logic     start_walk;
    logic     walk_step;
    fin_src_t fin_src;
    logic     out_load;
    logic     out_sel_hold;
    logic     load_hold;
  } ptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_translate;
    logic root_inside;
    logic step_done;
    logic out_free;
  } ptw_sts_t;

  // Table index for one level of the virtual address (level 3 is the root)
  function automatic logic [LEVEL_INDEX_BITS-1:0] level_index(
    input logic [VA_W-1:0]    va,
    input logic [LEVEL_W-1:0] lvl
  );
    logic [LEVEL_INDEX_BITS-1:0] idx;
    case (lvl)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      2'd2:    idx = va[38:30];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage

FILE: src/ptw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ptw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ctrl: page table walker sequencer
// Runs the clearing pass, accepts requests, steps the walk one level per
// cycle and routes finished results to the output or the hold register.
// ----------------------------------------------------------------------------
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ptw_sts_t sts,
  output ptw_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_translate && sts.root_inside) begin
            cmd.start_walk = 1'b1;
            state_nxt      = S_WALK;
          end else begin
            cmd.start_write = !sts.in_translate;
            cmd.fin_src     = sts.in_translate ? FIN_ROOT : FIN_ZERO;
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
            end else begin
              cmd.load_hold = 1'b1;
              state_nxt     = S_DONE;
            end
          end
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.step_done) begin
          cmd.fin_src = FIN_STEP;
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.load_hold = 1'b1;
            state_nxt     = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel_hold = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  // Requests are taken only while idle
  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == S_IDLE)
    else $error("input open outside idle state");

  // A walk never spans more than four level checks
  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> !($past(state_r, 1) == S_WALK && $past(state_r, 2) == S_WALK &&
                            $past(state_r, 3) == S_WALK && $past(state_r, 4) == S_WALK))
    else $error("walk longer than four levels");

endmodule

FILE: src/ptw_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_dpath: page table walker datapath
// Table memory, root register, walk registers, entry checks and the
// result and output registers.
// ----------------------------------------------------------------------------
module ptw_dpath
  import ptw_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptw_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ptw_out_t         out_data,
  input  logic             cfg_we,
  input  logic [PA_W-1:0]  cfg_wdata,
  input  ptw_cmd_t         cmd,
  output ptw_sts_t         sts
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [FRAME_W-1:0]    root_frame_r;
  logic [AW-1:0]         clr_cnt_r;
  logic [VA_W-1:0]       va_r;
  logic [LEVEL_W-1:0]    level_r;
  walk_status_t          status_r;
  ptw_out_t              hold_r;
  ptw_out_t              out_data_r;
  logic                  out_valid_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]    entry;

  logic [WORD_IDX_W-1:0] root_w;
  logic [WORD_IDX_W-1:0] next_w;
  logic                  root_inside;
  logic                  next_inside;
  logic                  wr_ok;
  logic                  present;
  walk_status_t          st_step;
  logic                  step_done;
  ptw_out_t              step_res;
  ptw_out_t              fin;
  logic                  out_free;

  // Root register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_frame_r <= '0;
    end else if (cfg_we) begin
      root_frame_r <= cfg_wdata[PA_W-1:PAGE_OFS_W];
    end
  end

  // Word addresses for the root read and the next level read
  assign root_w      = {root_frame_r, level_index(in_data.virt_addr, 2'd3)};
  assign next_w      = {entry[PA_W-1:PAGE_OFS_W], level_index(va_r, level_r - 2'd1)};
  assign root_inside = (root_w < WORD_IDX_W'(MEM_WORDS));
  assign next_inside = (next_w < WORD_IDX_W'(MEM_WORDS));
  assign wr_ok       = (32'(in_data.word_index) < 32'(MEM_WORDS));

  // Memory ports: clearing pass or write request, walk reads
  assign ram_we    = cmd.clr_write || (cmd.start_write && wr_ok);
  assign ram_waddr = cmd.clr_write ? clr_cnt_r : AW'(in_data.word_index);
  assign ram_wdata = cmd.clr_write ? '0 : in_data.word_data;
  assign ram_raddr = cmd.start_walk ? root_w[AW-1:0] : next_w[AW-1:0];

  ptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_WORDS)
  ) u_table_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (entry)
  );

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Check the entry of the current level
  always_comb begin
    present  = entry[PTE_PRESENT];
    st_step  = status_r;
    step_res = '0;
    if (level_r == 2'd1 && entry[PTE_LARGE] && status_r == ST_OK) begin
      st_step = ST_LARGE;
    end
    step_done = !present || (level_r == 2'd0) || !next_inside;
    if (!present) begin
      step_res.walk_status = (status_r == ST_OK) ? ST_NOT_PRESENT : status_r;
    end else if (level_r == 2'd0) begin
      step_res.walk_status = st_step;
      step_res.user_ok     = entry[PTE_USER];
      if (st_step == ST_OK) begin
        step_res.phys_addr = {entry[PA_W-1:PAGE_OFS_W], va_r[PAGE_OFS_W-1:0]};
      end
    end else begin
      step_res.walk_status = (st_step == ST_OK) ? ST_OUTSIDE : st_step;
    end
  end

  // Select the finished result
  always_comb begin
    fin = '0;
    case (cmd.fin_src)
      FIN_ZERO: fin = '0;
      FIN_ROOT: fin.walk_status = ST_OUTSIDE;
      FIN_STEP: fin = step_res;
      default:  fin = '0;
    endcase
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      va_r     <= in_data.virt_addr;
      level_r  <= 2'd3;
      status_r <= ST_OK;
    end else if (cmd.walk_step && !step_done) begin
      level_r  <= level_r - 2'd1;
      status_r <= st_step;
    end
  end

  // Park a result while the output is busy
  always_ff @(posedge clk) begin
    if (cmd.load_hold) begin
      hold_r <= fin;
    end
  end

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= cmd.out_sel_hold ? hold_r : fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller
  assign sts.clr_last     = (clr_cnt_r == AW'(MEM_WORDS - 1));
  assign sts.in_translate = (in_data.operation == OP_TRANSLATE);
  assign sts.root_inside  = root_inside;
  assign sts.step_done    = step_done;
  assign sts.out_free     = out_free;

  // A continuing walk moves down exactly one level
  a_level_down: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step && !step_done |=> level_r == $past(level_r) - 2'd1)
    else $error("walk level did not advance");

  // Never overwrite a result that is still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output overwritten while stalled");

  // No memory write while a walk is reading
  a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> !ram_we)
    else $error("table write during walk");

endmodule

FILE: src/four_level_page_table_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top: four-level page table walker
// Usage:
//   Input channel in_valid / in_stall / in_data carries requests: a write
//   stores one 64-bit table word, a translate walks four table levels from
//   the root register and returns the 4 KiB physical address, a status and
//   the user flag. Every request gives exactly one result on out_valid /
//   out_stall / out_data. cfg_we / cfg_wdata load the root table address.
//   After reset the table memory is cleared one word per cycle, with
//   in_stall high; the root register may be written meanwhile.
//   A write request is done on acceptance; its result is loaded into the
//   output register. A translate does one table read per level through
//   the single memory read port, and in_stall stays high until the walk
//   ends; a fault ends the walk early. The output register lets a new
//   request start while a result waits; if a second result finishes
//   before the first is taken it is parked and in_stall stays high until
//   the output drains.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top
  import ptw_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ptw_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ptw_out_t        out_data,
  input  logic            cfg_we,
  input  logic [PA_W-1:0] cfg_wdata
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptw_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: verif/four_level_page_table_walker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top_test: self-checking bench of the walker
// A directed table of table writes and translates runs first. Random phases
// follow, each under its own root table address. Most random requests build
// a four-level table chain and then translate through it; the rest are noise.
// Every result is checked field by field against a typed row result or an in-bench walk model.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top_test;
  import ptw_pkg::*;

  // One row of the directed table
  typedef struct packed {
    ptw_in_t  req;
    logic     typed;
    ptw_out_t res;
  } dir_row_t;

  // Result-side stall behavior
  typedef enum int {
    SINK_FREE,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_TOGGLE
  } sink_mode_t;

  localparam int PHASES      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 20;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ptw_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ptw_out_t out_data;
  logic     cfg_we;
  logic [PA_W-1:0] cfg_wdata;

  // Walk model state
  logic [ENTRY_W-1:0] table_words [0:MEM_WORDS_DEF-1];
  logic [PA_W-1:0]    root_base;

  ptw_out_t pending_walks[$];
  dir_row_t dir_rows[$];
  int       fail_count = 0;
  int       burst_left;
  bit       sink_hold_req;

  four_level_page_table_walker_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the tables exactly as the hardware should; update memory on writes
  function automatic ptw_out_t walk_model(input ptw_in_t req);
    ptw_out_t           res;
    logic [ENTRY_W-1:0] entry;
    logic [PA_W-1:0]    tbl;
    logic [63:0]        widx;
    walk_status_t       st;
    bit                 present_all;
    bit                 inside_all;
    bit                 walk_done;
    int                 lvl;
    res = '0;
    if (req.operation == OP_WRITE) begin
      if (req.word_index < MEM_WORDS_DEF) table_words[req.word_index] = req.word_data;
      return res;
    end
    tbl = root_base;
    entry = '0;
    st = ST_OK;
    present_all = 1'b1;
    inside_all = 1'b1;
    walk_done = 1'b0;
    for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
      if (!walk_done) begin
        widx = ({24'd0, tbl[PA_W-1:PAGE_OFS_W]} << LEVEL_INDEX_BITS)
               + req.virt_addr[PAGE_OFS_W + LEVEL_INDEX_BITS * lvl +: LEVEL_INDEX_BITS];
        if (widx >= MEM_WORDS_DEF) begin
          entry = '0;
          inside_all = 1'b0;
          if (st == ST_OK) st = ST_OUTSIDE;
          walk_done = 1'b1;
        end else begin
          entry = table_words[widx];
          if (!entry[PTE_PRESENT]) begin
            present_all = 1'b0;
            if (st == ST_OK) st = ST_NOT_PRESENT;
            walk_done = 1'b1;
          end else begin
            // large bit counts only at the directory level
            if (lvl == 1 && entry[PTE_LARGE] && st == ST_OK) st = ST_LARGE;
            tbl = entry[PA_W-1:0];
          end
        end
      end
    end
    if (st == ST_OK) res.phys_addr = {entry[PA_W-1:PAGE_OFS_W], req.virt_addr[PAGE_OFS_W-1:0]};
    res.walk_status = st;
    res.user_ok = inside_all && present_all && entry[PTE_USER];
    return res;
  endfunction

  function automatic void add_row(input op_t op, input logic [WRITE_IDX_W-1:0] idx,
                                  input logic [ENTRY_W-1:0] data, input logic [VA_W-1:0] va,
                                  input logic typed, input logic [PA_W-1:0] pa,
                                  input walk_status_t st, input logic uok);
    dir_row_t row;
    row.req.operation = op;
    row.req.word_index = idx;
    row.req.word_data = data;
    row.req.virt_addr = va;
    row.typed = typed;
    row.res.phys_addr = pa;
    row.res.walk_status = st;
    row.res.user_ok = uok;
    dir_rows.push_back(row);
  endfunction

  function automatic ptw_in_t random_request();
    ptw_in_t req;
    req.operation = op_t'($urandom_range(0, 1));
    req.word_index = WRITE_IDX_W'($urandom);
    req.word_data = {$urandom, $urandom};
    req.virt_addr = VA_W'({$urandom, $urandom});
    return req;
  endfunction

  // Mostly a frame inside memory, now and then anywhere
  function automatic logic [FRAME_W-1:0] pick_table_frame();
    if ($urandom_range(0, 9) == 0) return FRAME_W'({$urandom, $urandom});
    return FRAME_W'($urandom_range(0, MEM_WORDS_DEF / 512 - 1));
  endfunction

  function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                    input bit few_large);
    logic [ENTRY_W-1:0] e;
    e = {$urandom, $urandom};
    e[PA_W-1:PAGE_OFS_W] = frame;
    e[PTE_PRESENT] = ($urandom_range(0, 9) != 0);
    if (few_large && $urandom_range(0, 3) != 0) e[PTE_LARGE] = 1'b0;
    return e;
  endfunction

  // Offer one request, wait for acceptance, record its expected result
  task automatic send_request(input ptw_in_t req, input logic typed, input ptw_out_t typed_res);
    ptw_out_t model_res;
    int       gap;
    in_data = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_res = walk_model(req);
    pending_walks.push_back(typed ? typed_res : model_res);
    @(negedge clk);
    // keep valid up inside a burst, drop it for a random gap between bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_random(input ptw_in_t req);
    send_request(req, 1'b0, '0);
  endtask

  // Build a table chain under the current root, then translate through it
  task automatic run_walk_chain(output int sent);
    logic [LEVEL_INDEX_BITS-1:0] idx [LEVELS];
    logic [FRAME_W-1:0]          frame [LEVELS];
    ptw_in_t                     req;
    int                          lvl;
    int                          n;
    sent = 0;
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      idx[lvl] = LEVEL_INDEX_BITS'($urandom);
      frame[lvl] = pick_table_frame();
    end
    frame[LEVELS-1] = root_base[PA_W-1:PAGE_OFS_W];
    // write one entry per level; each points at the next table, the last one at a random page frame
    for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
      req = random_request();
      req.operation = OP_WRITE;
      req.word_index = {frame[lvl][2:0], idx[lvl]};
      req.word_data = make_entry(lvl > 0 ? frame[lvl-1] : FRAME_W'({$urandom, $urandom}),
                                 lvl == 1);
      send_random(req);
      sent++;
    end
    n = $urandom_range(1, 4);
    repeat (n) begin
      req = random_request();
      req.operation = OP_TRANSLATE;
      req.virt_addr[VA_W-1:PAGE_OFS_W] = {idx[3], idx[2], idx[1], idx[0]};
      if ($urandom_range(0, 4) == 0) begin
        lvl = $urandom_range(0, LEVELS - 1);
        req.virt_addr[PAGE_OFS_W + LEVEL_INDEX_BITS * lvl +: LEVEL_INDEX_BITS] =
          LEVEL_INDEX_BITS'($urandom);
      end
      send_random(req);
      sent++;
    end
  endtask

  task automatic load_root(input logic [PA_W-1:0] base);
    cfg_wdata = base;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    root_base = base;
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_walks.size() != 0) @(negedge clk);
  endtask

  // Main stimulus
  initial begin : stimulus
    logic [PA_W-1:0] next_root;
    int              target;
    int              done_items;
    int              sent;
    int              ph;
    int              i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    root_base = '0;
    burst_left = 0;
    sink_hold_req = 1'b0;
    for (i = 0; i < MEM_WORDS_DEF; i++) table_words[i] = '0;

    // directed rows: root table at frame 0, chain 1 -> 2 -> 3 -> 4
    add_row(OP_TRANSLATE, 12'hfff, 64'hffff_ffff_ffff_ffff, 48'h0, 1'b1, 52'h0, ST_NOT_PRESENT,
            1'b0);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'hffff_ffff_ffff, 1'b1, 52'h0, ST_NOT_PRESENT, 1'b0);
    add_row(OP_WRITE, 12'd0, 64'h0, 48'hffff_ffff_ffff, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_WRITE, 12'd4095, 64'hffff_ffff_ffff_ffff, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_WRITE, 12'd1, 64'h1005, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_WRITE, 12'd514, 64'h2005, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_WRITE, 12'd1027, 64'h3005, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_WRITE, 12'd1540, 64'hffff_ffff_ffff_f005, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_TRANSLATE, 12'hfff, 64'hffff_ffff_ffff_ffff, 48'h0080_8060_4abc, 1'b1,
            52'hf_ffff_ffff_fabc, ST_OK, 1'b1);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'h0080_8060_5abc, 1'b1, 52'h0, ST_NOT_PRESENT, 1'b0);
    add_row(OP_WRITE, 12'd1540, 64'h7001, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'h0080_8060_4000, 1'b0, 52'h0, ST_OK, 1'b0);
    // large bit at the pointer level is ignored
    add_row(OP_WRITE, 12'd514, 64'h2085, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'h0080_8060_4fff, 1'b0, 52'h0, ST_OK, 1'b0);
    // large page at the directory level
    add_row(OP_WRITE, 12'd1027, 64'h3085, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'h0080_8060_4abc, 1'b0, 52'h0, ST_OK, 1'b0);
    add_row(OP_WRITE, 12'd1027, 64'h3084, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'h0080_8060_4abc, 1'b0, 52'h0, ST_OK, 1'b0);
    // pointer table beyond the end of memory
    add_row(OP_WRITE, 12'd1, 64'h8001, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'h0080_8060_4abc, 1'b1, 52'h0, ST_OUTSIDE, 1'b0);
    // large directory entry whose leaf table lies outside memory
    add_row(OP_WRITE, 12'd1, 64'h1005, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_WRITE, 12'd1027, 64'h0010_0085, 48'h0, 1'b1, 52'h0, ST_OK, 1'b0);
    add_row(OP_TRANSLATE, 12'h0, 64'h0, 48'h0080_8060_4abc, 1'b0, 52'h0, ST_OK, 1'b0);

    // hold reset, then load an unaligned root that still selects frame 0
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    load_root(52'h0_0000_0000_0fff);

    foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
    drain_results();

    // random phases, each under a new root
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       next_root = 52'h0_0000_0000_7000;
        2:       next_root = 52'hf_ffff_ffff_f000;
        4:       next_root = PA_W'({$urandom, $urandom});
        7:       next_root = 52'h0;
        default: next_root = {37'd0, 3'($urandom), 12'($urandom)};
      endcase
      load_root(next_root);
      target = (ph == 2 || ph == 4) ? 40 : 150;
      if (ph == 1) sink_hold_req = 1'b1;
      done_items = 0;
      while (done_items < target) begin
        if ($urandom_range(0, 9) < 8) begin
          run_walk_chain(sent);
          done_items += sent;
        end else begin
          send_random(random_request());
          done_items++;
        end
      end
      drain_results();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_walks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result-side stall pattern, with one long hold-off on request
  initial begin : result_stall
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    bit         hold_taken;
    out_stall = 1'b0;
    mode = SINK_FREE;
    mode_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(SINK_FREE, SINK_TOGGLE));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          SINK_FREE:  out_stall = 1'b0;
          SINK_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          SINK_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:    out_stall = ~out_stall;
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    ptw_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_walks.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = pending_walks.pop_front();
        if (out_data.phys_addr !== want.phys_addr) begin
          $error("phys_addr expected %h got %h", want.phys_addr, out_data.phys_addr);
          fail_count++;
        end
        if (out_data.walk_status !== want.walk_status) begin
          $error("walk_status expected %0d got %0d", want.walk_status, out_data.walk_status);
          fail_count++;
        end
        if (out_data.user_ok !== want.user_ok) begin
          $error("user_ok expected %b got %b", want.user_ok, out_data.user_ok);
          fail_count++;
        end
      end
    end
  end

  // Run limit
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: four_level_page_table_walker_top.f
src/ptw_pkg.sv
src/ptw_ram.sv
src/ptw_ctrl.sv
src/ptw_dpath.sv
src/four_level_page_table_walker_top.sv
verif/four_level_page_table_walker_top_test.sv
